// File: sv/line_of_sight_range_check_macros.svh
// Assertion macros for the line-of-sight range check checker.
// Depends on nothing; included by the checker file.
`ifndef LINE_OF_SIGHT_RANGE_CHECK_MACROS_SVH
`define LINE_OF_SIGHT_RANGE_CHECK_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define LTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltc assertion failed");

// Next-cycle implication, gated by the active-low reset.
`define LTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltc assertion failed");

`endif

// File: sv/ltc_pkg.sv
// Shared types and constants for the line-of-sight range check.
// No dependencies; imported by every module of the block.
package ltc_pkg;

    localparam int OBSTACLES = 64;
    localparam int IDX_W     = (OBSTACLES > 1) ? $clog2(OBSTACLES) : 1;
    localparam int SLOT_W    = 6;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic        [14:0] hw;
        logic        [14:0] hh;
    } t_box;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } t_seg;

endpackage

// File: sv/line_of_sight_range_check.sv
// Top level: obstacle box chain, slab test pipeline, range check and control.
// Depends on ltc_pkg, ltc_cell and ltc_slab.
//
//  channel | signals                          | direction
//  input   | i_valid / o_stall, request fields | in
//  output  | o_valid / i_stall, result bits    | out
//
// Load and remove give no result.
// A query rotates the box chain once past the single slab tester, one slot
// per cycle, then the three-stage tester drains and the result is registered.
// Reset clears all valid marks at once; box data is left as is.
// The output register holds a result under stall; a load or remove may be
// taken meanwhile, while a query waits at its end for the register to free.
module line_of_sight_range_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [5:0]           i_slot,
    input  logic signed [15:0]   i_center_x,
    input  logic signed [15:0]   i_center_y,
    input  logic [14:0]          i_half_width,
    input  logic [14:0]          i_half_height,
    input  logic signed [15:0]   i_viewer_x,
    input  logic signed [15:0]   i_viewer_y,
    input  logic signed [15:0]   i_target_x,
    input  logic signed [15:0]   i_target_y,
    input  logic [14:0]          i_view_range,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_visible,
    output logic                 o_within_range,
    output logic                 o_blocked
);
    import ltc_pkg::*;

    t_state r_state, n_state;
    t_req   req;
    logic   accept, is_query, shift, scan_last, out_load;
    t_seg   r_seg;
    logic [IDX_W-1:0] r_cnt;
    logic   r_blk;
    logic [31:0] r_sqx, r_sqy;
    logic [29:0] r_sqr;
    logic [14:0] r_vr;
    logic   r_inr;
    logic   r_out_vld, r_vis, r_inr_o, r_blk_o;
    logic   slab_vld, slab_hit, slab_busy;
    t_box   box_ld;
    t_box   chain_box [OBSTACLES];
    logic   chain_vld [OBSTACLES];
    logic signed [33:0] sq_x, sq_y;

    assign req      = t_req'(i_req_type);
    assign accept   = i_valid && !o_stall;
    assign is_query = (req == REQ_QUERY);
    assign box_ld   = '{cx: i_center_x, cy: i_center_y, hw: i_half_width,
                        hh: i_half_height};

    // ring of slots; cell 0 faces the slab tester
    for (genvar g = 0; g < OBSTACLES; g++) begin : g_cell
        logic hit_slot;
        assign hit_slot = accept && (int'(i_slot) == g);
        ltc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (hit_slot && (req == REQ_LOAD)),
            .i_remove (hit_slot && (req == REQ_REMOVE)),
            .i_shift  (shift),
            .i_box_ld (box_ld),
            .i_box_nb (chain_box[(g + 1) % OBSTACLES]),
            .i_vld_nb (chain_vld[(g + 1) % OBSTACLES]),
            .o_box    (chain_box[g]),
            .o_vld    (chain_vld[g])
        );
    end

    ltc_slab u_slab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (shift),
        .i_box_vld (chain_vld[0]),
        .i_box     (chain_box[0]),
        .i_seg     (r_seg),
        .o_vld     (slab_vld),
        .o_hit     (slab_hit),
        .o_busy    (slab_busy)
    );

    assign scan_last = (r_cnt == IDX_W'(OBSTACLES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && is_query) n_state = ST_SCAN;
            ST_SCAN:  if (scan_last) n_state = ST_FLUSH;
            ST_FLUSH: if (!slab_busy) n_state = ST_HOLD;
            ST_HOLD:  if (!r_out_vld || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = (r_state != ST_IDLE);
        shift    = (r_state == ST_SCAN);
        out_load = (r_state == ST_HOLD) && (!r_out_vld || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_query) begin
            r_seg.vx <= i_viewer_x;
            r_seg.vy <= i_viewer_y;
            r_seg.dx <= {i_target_x[15], i_target_x} - {i_viewer_x[15], i_viewer_x};
            r_seg.dy <= {i_target_y[15], i_target_y} - {i_viewer_y[15], i_viewer_y};
            r_vr     <= i_view_range;
            r_blk    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (shift) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (slab_vld && slab_hit) begin
                r_blk <= 1'b1;
            end
        end
    end

    // range check: squares, then compare; settles long before the scan ends
    assign sq_x = r_seg.dx * r_seg.dx;
    assign sq_y = r_seg.dy * r_seg.dy;

    always_ff @(posedge i_clk) begin
        r_sqx <= sq_x[31:0];
        r_sqy <= sq_y[31:0];
        r_sqr <= r_vr * r_vr;
        r_inr <= ({1'b0, r_sqx} + {1'b0, r_sqy}) <= {3'b0, r_sqr};
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_vis   <= r_inr && !r_blk;
            r_inr_o <= r_inr;
            r_blk_o <= r_blk;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_visible      = r_vis;
    assign o_within_range = r_inr_o;
    assign o_blocked      = r_blk_o;

endmodule

// File: sv/ltc_cell.sv
// One obstacle slot of the rotating box chain.
// Depends on ltc_pkg for the box type.
module ltc_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic         i_remove,
    input  logic         i_shift,
    input  ltc_pkg::t_box i_box_ld,
    input  ltc_pkg::t_box i_box_nb,
    input  logic         i_vld_nb,
    output ltc_pkg::t_box o_box,
    output logic         o_vld
);
    import ltc_pkg::*;

    t_box r_box;
    logic r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld_nb;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_remove) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_box <= i_box_nb;
        end else if (i_load) begin
            r_box <= i_box_ld;
        end
    end

    assign o_box = r_box;
    assign o_vld = r_vld;

endmodule

// File: sv/ltc_slab.sv
// Three-stage slab test of the query segment against one box per cycle.
// Depends on ltc_pkg for the box and segment types.
module ltc_slab (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic          i_box_vld,
    input  ltc_pkg::t_box i_box,
    input  ltc_pkg::t_seg i_seg,
    output logic          o_vld,
    output logic          o_hit,
    output logic          o_busy
);
    import ltc_pkg::*;

    logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [18:0] vx_e, vy_e;

    logic               r1_vld, r1_bv, r1_dx0, r1_dy0, r1_okx, r1_oky;
    logic signed [18:0] r1_ax, r1_bx, r1_ay, r1_by;
    logic        [16:0] r1_dxd, r1_dyd;

    logic               r2_vld, r2_pre, r2_cross;
    logic signed [36:0] r2_p1, r2_p2, r2_p3, r2_p4;

    logic               r3_vld, r3_hit;

    always_comb begin
        lo_x = $signed({{2{i_box.cx[15]}}, i_box.cx}) - $signed({3'b0, i_box.hw});
        hi_x = $signed({{2{i_box.cx[15]}}, i_box.cx}) + $signed({3'b0, i_box.hw});
        lo_y = $signed({{2{i_box.cy[15]}}, i_box.cy}) - $signed({3'b0, i_box.hh});
        hi_y = $signed({{2{i_box.cy[15]}}, i_box.cy}) + $signed({3'b0, i_box.hh});
        vx_e = {{3{i_seg.vx[15]}}, i_seg.vx};
        vy_e = {{3{i_seg.vy[15]}}, i_seg.vy};
    end

    // stage 1: slab bounds per axis, oriented along the segment direction
    always_ff @(posedge i_clk) begin
        r1_bv  <= i_box_vld;
        r1_dx0 <= (i_seg.dx == 17'sd0);
        r1_dy0 <= (i_seg.dy == 17'sd0);
        r1_okx <= (vx_e >= $signed({lo_x[17], lo_x})) && (vx_e <= $signed({hi_x[17], hi_x}));
        r1_oky <= (vy_e >= $signed({lo_y[17], lo_y})) && (vy_e <= $signed({hi_y[17], hi_y}));
        if (!i_seg.dx[16]) begin
            r1_ax  <= {lo_x[17], lo_x} - vx_e;
            r1_bx  <= {hi_x[17], hi_x} - vx_e;
            r1_dxd <= i_seg.dx;
        end else begin
            r1_ax  <= vx_e - {hi_x[17], hi_x};
            r1_bx  <= vx_e - {lo_x[17], lo_x};
            r1_dxd <= -i_seg.dx;
        end
        if (!i_seg.dy[16]) begin
            r1_ay  <= {lo_y[17], lo_y} - vy_e;
            r1_by  <= {hi_y[17], hi_y} - vy_e;
            r1_dyd <= i_seg.dy;
        end else begin
            r1_ay  <= vy_e - {hi_y[17], hi_y};
            r1_by  <= vy_e - {lo_y[17], lo_y};
            r1_dyd <= -i_seg.dy;
        end
    end

    // stage 2: cross products for entry/exit comparisons between axes
    always_ff @(posedge i_clk) begin
        r2_p1 <= r1_ax * $signed({1'b0, r1_dyd});
        r2_p2 <= r1_by * $signed({1'b0, r1_dxd});
        r2_p3 <= r1_ay * $signed({1'b0, r1_dxd});
        r2_p4 <= r1_bx * $signed({1'b0, r1_dyd});
        r2_cross <= !(r1_dx0 || r1_dy0);
        r2_pre <= r1_bv
            && (!r1_dx0 || r1_okx) && (!r1_dy0 || r1_oky)
            && (r1_dx0 || (!r1_bx[18] && (r1_ax <= $signed({2'b0, r1_dxd}))))
            && (r1_dy0 || (!r1_by[18] && (r1_ay <= $signed({2'b0, r1_dyd}))));
    end

    // stage 3: each entry must not pass any exit
    always_ff @(posedge i_clk) begin
        r3_hit <= r2_pre && (!r2_cross || ((r2_p1 <= r2_p2) && (r2_p3 <= r2_p4)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    assign o_vld  = r3_vld;
    assign o_hit  = r3_hit;
    assign o_busy = r1_vld || r2_vld || r3_vld;

endmodule

// File: sv/ltc_checker.sv
// Port-level checker for the line-of-sight range check, bound to the top.
// Depends on ltc_pkg and line_of_sight_range_check_macros.svh.
`include "line_of_sight_range_check_macros.svh"

module ltc_sva (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_req_type,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_visible,
    input logic       o_within_range,
    input logic       o_blocked
);
    import ltc_pkg::*;

    logic acc, acc_query, acc_write, vis_ok;
    assign acc       = i_valid && !o_stall;
    assign acc_query = acc && (i_req_type == REQ_QUERY);
    assign acc_write = acc && (i_req_type == REQ_LOAD || i_req_type == REQ_REMOVE);
    assign vis_ok    = (o_visible == (o_within_range && !o_blocked));

    `LTC_ASSERT_NOW(a_vis_rule, i_clk, i_rst_n, o_valid, vis_ok)
    `LTC_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, acc_query, o_stall)
    `LTC_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, acc_write, !o_stall)
    `LTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule

bind line_of_sight_range_check ltc_sva u_ltc_sva (.*);
